// ----- sv/nor_flash_command_sequencer_unit_defines.svh -----
// Assertion macros for the NOR flash command sequencer.
// Each macro expects clk and rst in scope at the point of use.
`ifndef NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define NFCS_CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfcs check failed");

// Check cons in the cycle after ante.
`define NFCS_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfcs check failed");

`endif

// ----- sv/nfcs_pkg.sv -----
// Types, codes and the unlock decoder of the NOR flash command sequencer.
// No dependencies.
package nfcs_pkg;

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_STEP1   = 3'd1,
    M_STEP2   = 3'd2,
    M_STEP3   = 3'd3,
    M_STEP4   = 3'd4,
    M_STEP5   = 3'd5,
    M_QUERY   = 3'd6,
    M_PROGRAM = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_SEQ  = 2'd1,
    ERR_SIZE = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CHIP    = 3'd1,
    ACT_SECTOR  = 3'd2,
    ACT_BLOCK   = 3'd3,
    ACT_PROGRAM = 3'd4
  } act_t;

  typedef struct packed {
    mode_t mode;
    err_t  err;
    act_t  act;
  } dec_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  localparam logic [23:0] UNLOCK_A = 24'h00AAAA;
  localparam logic [23:0] UNLOCK_B = 24'h005554;

  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_ID      = 8'h90;
  localparam logic [7:0] CMD_CFI     = 8'h98;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_CHIP    = 8'h10;
  localparam logic [7:0] CMD_SECTOR  = 8'h30;
  localparam logic [7:0] CMD_BLOCK   = 8'h50;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  function automatic dec_t decode_write(mode_t mode, logic is_a, logic is_b,
                                        logic [7:0] cmd);
    dec_t r;
    r.mode = mode;
    r.err  = ERR_OK;
    r.act  = ACT_NONE;
    if (mode != M_PROGRAM && cmd == CMD_RESET) begin
      r.mode = M_NORMAL;
    end else begin
      unique case (mode)
        M_NORMAL, M_STEP3: begin
          if (is_a && cmd == CMD_UNLOCK1) begin
            r.mode = (mode == M_NORMAL) ? M_STEP1 : M_STEP4;
          end else begin
            r.err = ERR_SEQ;
          end
        end
        M_STEP1, M_STEP4: begin
          if (is_b && cmd == CMD_UNLOCK2) begin
            r.mode = (mode == M_STEP1) ? M_STEP2 : M_STEP5;
          end else begin
            r.err = ERR_SEQ;
          end
        end
        M_STEP2: begin
          if (!is_a) begin
            r.err = ERR_SEQ;
          end else begin
            unique case (cmd) inside
              CMD_ERASE:        r.mode = M_STEP3;
              CMD_ID, CMD_CFI:  r.mode = M_QUERY;
              CMD_PROGRAM:      r.mode = M_PROGRAM;
              default:          r.err  = ERR_SEQ;
            endcase
          end
        end
        M_STEP5: begin
          unique case (cmd) inside
            CMD_CHIP: begin
              if (is_a) begin
                r.act  = ACT_CHIP;
                r.mode = M_NORMAL;
              end else begin
                r.err = ERR_SEQ;
              end
            end
            CMD_SECTOR: begin
              r.act  = ACT_SECTOR;
              r.mode = M_NORMAL;
            end
            CMD_BLOCK: begin
              r.act  = ACT_BLOCK;
              r.mode = M_NORMAL;
            end
            default: r.err = ERR_SEQ;
          endcase
        end
        M_QUERY: begin
          if (!((is_a && cmd == CMD_UNLOCK1) || (is_b && cmd == CMD_UNLOCK2))) begin
            r.err = ERR_SEQ;
          end
        end
        M_PROGRAM: begin
          r.act  = ACT_PROGRAM;
          r.mode = M_NORMAL;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- sv/nor_flash_command_sequencer_unit.sv -----
// Plain writes and query or bad-size reads go straight to the finish state; a program writes two bytes,
// a read fetches its n bytes and an erase clears its span first; a result then waits on out_ready.
// One transfer in flight at a time; a byte-wide memory with one write and one read port
// moves one byte a cycle, so the byte loop of reads and erases sets the rate.
// Reset: synchronous, active high; then a clearing pass writes 0xFF to all
// 2^MEM_ADDR_BITS bytes, one a cycle, before the first input transfer.
`include "nor_flash_command_sequencer_unit_defines.svh"

module nor_flash_command_sequencer_unit
  import nfcs_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 17,
  parameter int SECTOR_BYTES  = 4096,
  parameter int BLOCK_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [23:0] addr,
  input  logic [15:0] wdata,
  input  logic [2:0]  access_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] rdata,
  output logic [1:0]  error_code,
  output logic        query_mode
);

  localparam int AW        = MEM_ADDR_BITS;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [AW-1:0] SECTOR_SPAN = AW'(SECTOR_BYTES - 1);
  localparam logic [AW-1:0] BLOCK_SPAN  = AW'(BLOCK_BYTES - 1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_READ    = 7'b0000010,
    ST_PROG_LO = 7'b0000100,
    ST_PROG_HI = 7'b0001000,
    ST_ERASE   = 7'b0010000,
    ST_CLEAR   = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t        state;
  mode_t         cmd_mode;
  logic [AW-1:0] a_reg;
  logic [15:0]   wd_reg;
  logic [2:0]    size_reg;
  logic [2:0]    ic;
  logic [1:0]    cc;
  logic          rd_pend;
  logic [31:0]   acc;
  err_t          res_err;
  logic          res_q;
  logic [AW-1:0] ea;
  logic [AW-1:0] span;
  logic [31:0]   out_data;
  err_t          out_err;
  logic          out_q;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [AW-1:0] a_in;
  logic          is_a;
  logic          is_b;
  dec_t          dec;
  logic          out_free;
  logic [2:0]    cc_inc;

  assign in_ready   = (state == ST_IDLE);
  assign rdata      = out_data;
  assign error_code = out_err;
  assign query_mode = out_q;
  assign out_free   = !out_valid || out_ready;
  assign cc_inc     = 3'({1'b0, cc} + 3'd1);

  assign a_in = addr[AW-1:0];
  assign is_a = (a_in == UNLOCK_A[AW-1:0]);
  assign is_b = (a_in == UNLOCK_B[AW-1:0]);
  assign dec  = decode_write(cmd_mode, is_a, is_b, wdata[7:0]);

  assign mem_raddr = a_reg + AW'(ic);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ea;
    mem_wdata = ERASED_BYTE;
    unique case (state)
      ST_ERASE, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_PROG_LO: begin
        mem_we    = 1'b1;
        mem_waddr = a_reg;
        mem_wdata = wd_reg[7:0];
      end
      ST_PROG_HI: begin
        mem_we    = 1'b1;
        mem_waddr = a_reg + AW'(1);
        mem_wdata = wd_reg[15:8];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cmd_mode  <= M_NORMAL;
      out_valid <= 1'b0;
      ea        <= '0;
      span      <= '1;
      ic        <= '0;
      cc        <= '0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a_reg    <= a_in;
            wd_reg   <= wdata;
            size_reg <= access_bytes;
            ic       <= '0;
            cc       <= '0;
            rd_pend  <= 1'b0;
            acc      <= '0;
            res_err  <= ERR_OK;
            res_q    <= (cmd_mode == M_QUERY);
            state    <= ST_FINISH;
            if (op == OP_READ) begin
              if (access_bytes != SIZE_BYTE && access_bytes != SIZE_HALF &&
                  access_bytes != SIZE_WORD) begin
                res_err <= ERR_SIZE;
              end else if (cmd_mode != M_QUERY) begin
                state <= ST_READ;
              end
            end else if (access_bytes != SIZE_HALF) begin
              res_err <= ERR_SIZE;
            end else begin
              cmd_mode <= dec.mode;
              res_err  <= dec.err;
              res_q    <= (dec.mode == M_QUERY);
              case (dec.act)
                ACT_PROGRAM: state <= ST_PROG_LO;
                ACT_CHIP: begin
                  ea    <= '0;
                  span  <= '1;
                  state <= ST_ERASE;
                end
                ACT_SECTOR: begin
                  ea    <= a_in & ~SECTOR_SPAN;
                  span  <= SECTOR_SPAN;
                  state <= ST_ERASE;
                end
                ACT_BLOCK: begin
                  ea    <= a_in & ~BLOCK_SPAN;
                  span  <= BLOCK_SPAN;
                  state <= ST_ERASE;
                end
                default: state <= ST_FINISH;
              endcase
            end
          end
        end
        ST_READ: begin
          if (ic != size_reg) begin
            ic <= ic + 3'd1;
          end
          rd_pend <= (ic != size_reg);
          if (rd_pend) begin
            acc[{cc, 3'b000} +: 8] <= mem_q;
            cc <= cc + 2'd1;
            if (cc_inc == size_reg) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_PROG_LO: begin
          state <= ST_PROG_HI;
        end
        ST_PROG_HI: begin
          state <= ST_FINISH;
        end
        ST_ERASE, ST_CLEAR: begin
          if ((ea & span) == span) begin
            state <= (state == ST_CLEAR) ? ST_IDLE : ST_FINISH;
          end else begin
            ea <= ea + AW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data  <= acc;
            out_err   <= res_err;
            out_q     <= res_q;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `NFCS_CHK_NOW(a_err_zero_data, out_valid && (error_code != ERR_OK), rdata == '0)
  `NFCS_CHK_NOW(a_read_not_query, state == ST_READ, cmd_mode != M_QUERY)
  `NFCS_CHK_NEXT(a_bad_size_keeps_mode, in_valid && in_ready && (op == OP_WRITE) && (access_bytes != SIZE_HALF), $stable(cmd_mode))
  `NFCS_CHK_NEXT(a_finish_loads, (state == ST_FINISH) && out_free, out_valid && (state == ST_IDLE))

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for nor_flash_command_sequencer_unit.
// Drives reads, unlock sequences, program, query and erase commands, and checks each
// response against a pinned value or a predictor of mode and flash image. Depends on nfcs_pkg.
module testbench;
  import nfcs_pkg::*;

  localparam int MEM_ADDR_BITS  = 17;
  localparam int SECTOR_BYTES   = 4096;
  localparam int BLOCK_BYTES    = 65536;
  localparam int MEM_BYTES      = 1 << MEM_ADDR_BITS;
  localparam int N_DIRECTED     = 25;
  localparam int RANDOM_ITEMS   = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 600000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic        op;
    logic [23:0] addr;
    logic [15:0] wdata;
    logic [2:0]  size;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    err_t        err;
    logic        query;
  } response_t;

  typedef struct packed {
    access_t   acc;
    logic      pinned;
    response_t resp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_READ;
  logic [23:0] addr = '0;
  logic [15:0] wdata = '0;
  logic [2:0]  access_bytes = SIZE_BYTE;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] rdata;
  logic [1:0]  error_code;
  logic        query_mode;

  mode_t       flash_mode;
  logic [7:0]  flash_img [MEM_BYTES];
  response_t   pending_responses [$];
  int          mismatches = 0;
  int          accepted_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_requests = 0;
  int          erase_count = 0;
  int          chips_left = 2;
  int          blocks_left = 3;

  row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_READ,  24'h000000, 16'h0000, SIZE_WORD}, 1'b1, '{32'hFFFFFFFF, ERR_OK, 1'b0}},
    '{'{OP_READ,  24'hFFFFFF, 16'hFFFF, 3'd7},      1'b1, '{32'h0, ERR_SIZE, 1'b0}},
    '{'{OP_READ,  24'h123456, 16'h0000, 3'd0},      1'b1, '{32'h0, ERR_SIZE, 1'b0}},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00AA, SIZE_WORD}, 1'b1, '{32'h0, ERR_SIZE, 1'b0}},
    '{'{OP_WRITE, 24'h000000, 16'h0012, SIZE_HALF}, 1'b1, '{32'h0, ERR_SEQ, 1'b0}},
    '{'{OP_WRITE, 24'h00AAAA, 16'hFFAA, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'hFE5554, 16'h0055, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00A0, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'hFFFFFF, 16'h1234, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_READ,  24'hFFFFFE, 16'h0000, SIZE_WORD}, 1'b1, '{32'hFF1234FF, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00AA, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'h005554, 16'h0055, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'h02AAAA, 16'h0098, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b1}},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00AA, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b1}},
    '{'{OP_READ,  24'h000000, 16'h0000, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b1}},
    '{'{OP_WRITE, 24'h005554, 16'h0055, 3'd3},      1'b1, '{32'h0, ERR_SIZE, 1'b1}},
    '{'{OP_WRITE, 24'h000100, 16'h0033, SIZE_HALF}, 1'b1, '{32'h0, ERR_SEQ, 1'b1}},
    '{'{OP_WRITE, 24'h000000, 16'h00F0, SIZE_HALF}, 1'b1, '{32'h0, ERR_OK, 1'b0}},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00AA, SIZE_HALF}, 1'b0, '0},
    '{'{OP_WRITE, 24'h005554, 16'h0055, SIZE_HALF}, 1'b0, '0},
    '{'{OP_WRITE, 24'h00AAAA, 16'h0080, SIZE_HALF}, 1'b0, '0},
    '{'{OP_WRITE, 24'h00AAAA, 16'h00AA, SIZE_HALF}, 1'b0, '0},
    '{'{OP_WRITE, 24'h005554, 16'h0055, SIZE_HALF}, 1'b0, '0},
    '{'{OP_WRITE, 24'h01F123, 16'h0030, SIZE_HALF}, 1'b0, '0},
    '{'{OP_READ,  24'hFFFFFE, 16'h0000, SIZE_WORD}, 1'b0, '0}
  };

  nor_flash_command_sequencer_unit #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS),
    .SECTOR_BYTES (SECTOR_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES)
  ) uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void wipe(int start, int count);
    for (int i = 0; i < count; i++) begin
      flash_img[(start + i) & (MEM_BYTES - 1)] = ERASED_BYTE;
    end
  endfunction

  function automatic err_t unlock_step(int base, logic [15:0] d);
    logic [7:0] cmd;
    logic       at_a;
    logic       at_b;
    cmd  = d[7:0];
    at_a = (base == int'(UNLOCK_A));
    at_b = (base == int'(UNLOCK_B));
    if (flash_mode != M_PROGRAM && cmd == CMD_RESET) begin
      flash_mode = M_NORMAL;
      return ERR_OK;
    end
    case (flash_mode)
      M_NORMAL, M_STEP3: begin
        if (!(at_a && cmd == CMD_UNLOCK1)) return ERR_SEQ;
        flash_mode = (flash_mode == M_NORMAL) ? M_STEP1 : M_STEP4;
      end
      M_STEP1, M_STEP4: begin
        if (!(at_b && cmd == CMD_UNLOCK2)) return ERR_SEQ;
        flash_mode = (flash_mode == M_STEP1) ? M_STEP2 : M_STEP5;
      end
      M_STEP2: begin
        if (!at_a) return ERR_SEQ;
        case (cmd)
          CMD_ERASE:       flash_mode = M_STEP3;
          CMD_ID, CMD_CFI: flash_mode = M_QUERY;
          CMD_PROGRAM:     flash_mode = M_PROGRAM;
          default:         return ERR_SEQ;
        endcase
      end
      M_STEP5: begin
        case (cmd)
          CMD_CHIP: begin
            if (!at_a) return ERR_SEQ;
            wipe(0, MEM_BYTES);
          end
          CMD_SECTOR: wipe(base - base % SECTOR_BYTES, SECTOR_BYTES);
          CMD_BLOCK:  wipe(base - base % BLOCK_BYTES, BLOCK_BYTES);
          default:    return ERR_SEQ;
        endcase
        flash_mode = M_NORMAL;
      end
      M_QUERY: begin
        if (!((at_a && cmd == CMD_UNLOCK1) || (at_b && cmd == CMD_UNLOCK2))) return ERR_SEQ;
      end
      default: begin
        flash_img[base] = d[7:0];
        flash_img[(base + 1) & (MEM_BYTES - 1)] = d[15:8];
        flash_mode = M_NORMAL;
      end
    endcase
    return ERR_OK;
  endfunction

  function automatic response_t emulate_access(access_t a);
    response_t r;
    int        base;
    r    = '0;
    r.err = ERR_OK;
    base = int'(a.addr) & (MEM_BYTES - 1);
    if (a.op == OP_READ) begin
      if (!(a.size inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD})) begin
        r.err = ERR_SIZE;
      end else if (flash_mode != M_QUERY) begin
        for (int i = 0; i < int'(a.size); i++) begin
          r.rdata[8*i +: 8] = flash_img[(base + i) & (MEM_BYTES - 1)];
        end
      end
    end else if (a.size != SIZE_HALF) begin
      r.err = ERR_SIZE;
    end else begin
      r.err = unlock_step(base, a.wdata);
    end
    r.query = (flash_mode == M_QUERY);
    return r;
  endfunction

  task automatic transfer_access(access_t a, logic pinned, response_t pinned_resp);
    response_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= a.op;
    addr         <= a.addr;
    wdata        <= a.wdata;
    access_bytes <= a.size;
    do @(posedge clk); while (!in_ready);
    r = emulate_access(a);
    if (pinned) r = pinned_resp;
    pending_responses.push_back(r);
    accepted_count++;
  endtask

  function automatic logic [23:0] alias_of(logic [23:0] target);
    logic [23:0] hi;
    hi = 24'($urandom) << MEM_ADDR_BITS;
    return hi | target;
  endfunction

  function automatic logic [2:0] pick_size();
    if ($urandom_range(9) == 0) return 3'($urandom);
    case ($urandom_range(2))
      0:       return SIZE_BYTE;
      1:       return SIZE_HALF;
      default: return SIZE_WORD;
    endcase
  endfunction

  task automatic send_read(logic [23:0] a, logic [2:0] size);
    transfer_access('{OP_READ, a, 16'($urandom), size}, 1'b0, '0);
  endtask

  task automatic send_write(logic [23:0] a, logic [15:0] d);
    transfer_access('{OP_WRITE, a, d, SIZE_HALF}, 1'b0, '0);
  endtask

  task automatic send_random();
    transfer_access(access_t'(44'({$urandom, $urandom})), 1'b0, '0);
  endtask

  task automatic command_at(logic [23:0] target, logic [7:0] cmd);
    send_write(alias_of(target), {8'($urandom), cmd});
  endtask

  task automatic unlock_pair();
    command_at(UNLOCK_A, CMD_UNLOCK1);
    command_at(UNLOCK_B, CMD_UNLOCK2);
  endtask

  // Bring the sequencer back to normal mode before a well-formed sequence.
  task automatic settle();
    if (flash_mode == M_PROGRAM) send_write(24'($urandom), 16'($urandom));
    else if (flash_mode != M_NORMAL) command_at(24'($urandom), CMD_RESET);
  endtask

  task automatic run_sequence();
    int          kind;
    int          steps;
    int          pick;
    logic [23:0] a;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_read(24'($urandom), pick_size());
    end else if (kind < 45) begin
      settle();
      unlock_pair();
      if ($urandom_range(3) == 0) send_read(24'($urandom), pick_size());
      command_at(UNLOCK_A, CMD_PROGRAM);
      a = 24'($urandom);
      send_write(a, 16'($urandom));
      if ($urandom_range(1) == 0) send_read(a, pick_size());
    end else if (kind < 55) begin
      settle();
      unlock_pair();
      command_at(UNLOCK_A, ($urandom_range(1) == 0) ? CMD_ID : CMD_CFI);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0:       send_read(24'($urandom), pick_size());
          1:       command_at(UNLOCK_A, CMD_UNLOCK1);
          2:       command_at(UNLOCK_B, CMD_UNLOCK2);
          default: send_random();
        endcase
      end
      if ($urandom_range(9) != 0) command_at(24'($urandom), CMD_RESET);
    end else if (kind < 65) begin
      settle();
      unlock_pair();
      command_at(UNLOCK_A, CMD_ERASE);
      unlock_pair();
      pick = $urandom_range(99);
      a = 24'($urandom);
      if (erase_count == 0 || (pick < 2 && chips_left > 0)) begin
        chips_left--;
        command_at(UNLOCK_A, CMD_CHIP);
      end else if (erase_count == 1 || (pick < 8 && blocks_left > 0)) begin
        blocks_left--;
        send_write(a, {8'($urandom), CMD_BLOCK});
      end else if (pick < 20) begin
        command_at(UNLOCK_B, CMD_CHIP);
      end else begin
        send_write(a, {8'($urandom), CMD_SECTOR});
      end
      erase_count++;
      send_read(a, SIZE_WORD);
    end else if (kind < 75) begin
      settle();
      steps = $urandom_range(1, 4);
      if (steps > 0) command_at(UNLOCK_A, CMD_UNLOCK1);
      if (steps > 1) command_at(UNLOCK_B, CMD_UNLOCK2);
      if (steps > 2) command_at(UNLOCK_A, CMD_ERASE);
      if (steps > 3) command_at(UNLOCK_A, CMD_UNLOCK1);
      if ($urandom_range(1) == 0) send_read(24'($urandom), pick_size());
      send_write(24'($urandom), 16'($urandom));
    end else begin
      send_random();
    end
  endtask

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    response_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response: rdata=%h err=%0d query=%b",
                   rdata, error_code, query_mode);
      end else begin
        want = pending_responses.pop_front();
        if (rdata !== want.rdata || error_code !== want.err || query_mode !== want.query) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected rdata=%h err=%0d query=%b, got rdata=%h err=%0d query=%b",
                     want.rdata, want.err, want.query, rdata, error_code, query_mode);
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    flash_mode = M_NORMAL;
    for (int i = 0; i < MEM_BYTES; i++) flash_img[i] = ERASED_BYTE;
    tx_idle_pct = 16;
    rx_idle_pct = 85;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < N_DIRECTED; n++) begin
      transfer_access(directed_rows[n].acc, directed_rows[n].pinned, directed_rows[n].resp);
    end
    while (accepted_count < N_DIRECTED + RANDOM_ITEMS) begin
      if (accepted_count >= N_DIRECTED + 2 * RANDOM_ITEMS / 3) begin
        if (rx_idle_pct != 0) hold_requests++;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (accepted_count >= N_DIRECTED + RANDOM_ITEMS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 16;
      end
      run_sequence();
    end
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/nfcs_pkg.sv
sv/nor_flash_command_sequencer_unit.sv
dv/testbench.sv
